// ===== hdl/msdcp_pkg.sv =====
// Shared widths, codes and the SysEx header table of the display command parser.
package msdcp_pkg;

    localparam int OP_W     = 1;
    localparam int PORT_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int TARGET_W = 8;
    localparam int VALUE_W  = 8;
    localparam int CMD_W    = 7;
    localparam int HDR_CNT_W = 3;
    localparam int DIGIT_W  = 3;
    localparam int POS_W    = 3;

    localparam logic [HDR_CNT_W-1:0] HDR_LEN = 3'd7;

    // Input word kinds
    localparam logic [OP_W-1:0] OP_BYTE    = 1'b0;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 1'b1;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_CURSOR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CHAR      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PTR_TYPE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PTR_VALUE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIGIT     = 3'd4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TEXT    = 7'h10;
    localparam logic [CMD_W-1:0] CMD_POINTER = 7'h11;
    localparam logic [CMD_W-1:0] CMD_DIGITS  = 7'h12;

    // Cursor addresses of 40 and above move to the second line at 40h.
    localparam logic [BYTE_W-1:0] CURSOR_SPLIT = 8'd40;
    localparam logic [BYTE_W-1:0] CURSOR_LINE2 = 8'h40;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 3'd7;

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_CNT_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = 8'hf0;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h0f;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h11;
            3'd6:    b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/msdcp_ifs.sv =====
// Valid/ready channel interfaces for the input words, results and configuration.
interface msdcp_in_if;
    import msdcp_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PORT_W-1:0]   port;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, op, port, data_byte, input ready);
    modport sink   (input valid, op, port, data_byte, output ready);
endinterface

interface msdcp_out_if;
    import msdcp_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TARGET_W-1:0] target;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, action, target, value, input ready);
    modport sink   (input valid, action, target, value, output ready);
endinterface

interface msdcp_cfg_if;
    import msdcp_pkg::*;
    logic                valid;
    logic                ready;
    logic [PORT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/midi_sysex_display_command_parser_top.sv =====
// SysEx display command parser: an input register, one pass of parse logic and a
// result register. One word can be taken every cycle while input readiness holds; a result
// is registered when its word leaves the input register. Input readiness
// drops only while a result waits in the output register and the input register is
// also full. The home port register is written through cfg and must only change
// while no word is in flight.
module midi_sysex_display_command_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    msdcp_in_if.sink     din,
    msdcp_out_if.source  dout,
    msdcp_cfg_if.sink    cfg
);
    import msdcp_pkg::*;

    typedef struct packed {
        logic [HDR_CNT_W-1:0] header_count;
        logic                 in_message;
        logic                 have_command;
        logic [CMD_W-1:0]     command_code;
        logic                 cursor_seen;
        logic                 type_seen;
        logic                 position_seen;
        logic [POS_W-1:0]     pointer_position;
        logic [DIGIT_W-1:0]   digit_count;
        logic [BYTE_W-1:0]    digit_pattern;
    } parse_t;

    logic [PORT_W-1:0]   home_port_reg;

    logic                in_valid_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [PORT_W-1:0]   in_port_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    parse_t              state_reg, state_next;

    logic                out_valid_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [TARGET_W-1:0] out_target_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic                res_valid;
    logic [ACTION_W-1:0] res_action;
    logic [TARGET_W-1:0] res_target;
    logic [VALUE_W-1:0]  res_value;

    logic                advance;
    logic                take_in;
    logic [DIGIT_W-1:0]  digit_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || !out_valid_reg || dout.ready;
    assign take_in  = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    assign dout.valid  = out_valid_reg;
    assign dout.action = out_action_reg;
    assign dout.target = out_target_reg;
    assign dout.value  = out_value_reg;

    assign digit_inc = (state_reg.digit_count < DIGIT_MAX)
                     ? state_reg.digit_count + 3'd1 : state_reg.digit_count;

    always_comb
    begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res_action = ACT_CURSOR;
        res_target = '0;
        res_value  = '0;

        if (in_op_reg == OP_TIMEOUT)
        begin
            if (in_port_reg == home_port_reg)
            begin
                state_next.header_count  = '0;
                state_next.in_message    = 1'b0;
                state_next.have_command  = 1'b0;
                state_next.command_code  = '0;
                state_next.cursor_seen   = 1'b0;
                state_next.type_seen     = 1'b0;
                state_next.position_seen = 1'b0;
            end
        end
        else if (!state_reg.in_message)
        begin
            // Header bytes are matched from any port.
            if (state_reg.header_count < HDR_LEN
                && in_byte_reg == hdr_byte(state_reg.header_count))
            begin
                state_next.header_count = state_reg.header_count + 3'd1;
                if (state_reg.header_count + 3'd1 == HDR_LEN)
                    state_next.in_message = 1'b1;
            end
            else
            begin
                state_next.header_count  = '0;
                state_next.in_message    = 1'b0;
                state_next.have_command  = 1'b0;
                state_next.command_code  = '0;
                state_next.cursor_seen   = 1'b0;
                state_next.type_seen     = 1'b0;
                state_next.position_seen = 1'b0;
            end
        end
        else if (in_port_reg != home_port_reg)
        begin
            state_next = state_reg;
        end
        else if (in_byte_reg[BYTE_W-1] || (!state_reg.have_command
                 && in_byte_reg[CMD_W-1:0] != CMD_TEXT
                 && in_byte_reg[CMD_W-1:0] != CMD_POINTER
                 && in_byte_reg[CMD_W-1:0] != CMD_DIGITS))
        begin
            // A status byte or an unknown command ends the message.
            state_next.header_count  = '0;
            state_next.in_message    = 1'b0;
            state_next.have_command  = 1'b0;
            state_next.command_code  = '0;
            state_next.cursor_seen   = 1'b0;
            state_next.type_seen     = 1'b0;
            state_next.position_seen = 1'b0;
        end
        else if (!state_reg.have_command)
        begin
            state_next.have_command = 1'b1;
            state_next.command_code = in_byte_reg[CMD_W-1:0];
            if (in_byte_reg[CMD_W-1:0] == CMD_DIGITS)
                state_next.digit_count = '0;
        end
        else if (state_reg.command_code == CMD_TEXT)
        begin
            res_valid = 1'b1;
            if (!state_reg.cursor_seen)
            begin
                state_next.cursor_seen = 1'b1;
                res_action = ACT_CURSOR;
                res_target = (in_byte_reg < CURSOR_SPLIT) ? in_byte_reg
                           : in_byte_reg - CURSOR_SPLIT + CURSOR_LINE2;
            end
            else
            begin
                res_action = ACT_CHAR;
                res_value  = in_byte_reg;
            end
        end
        else if (state_reg.command_code == CMD_POINTER)
        begin
            if (!state_reg.type_seen)
            begin
                state_next.type_seen = 1'b1;
                res_valid  = 1'b1;
                res_action = ACT_PTR_TYPE;
                res_value  = in_byte_reg;
            end
            else if (!state_reg.position_seen)
            begin
                state_next.position_seen    = 1'b1;
                state_next.pointer_position = in_byte_reg[POS_W-1:0];
            end
            else
            begin
                res_valid  = 1'b1;
                res_action = ACT_PTR_VALUE;
                res_target = {{(TARGET_W-POS_W){1'b0}}, state_reg.pointer_position};
                res_value  = in_byte_reg;
            end
        end
        else if (state_reg.command_code == CMD_DIGITS)
        begin
            state_next.digit_count = digit_inc;
            unique case (digit_inc)
                3'd1, 3'd3:
                begin
                    // Bit 6 of the first byte also lights the top segment bit.
                    state_next.digit_pattern = {in_byte_reg[3] | in_byte_reg[6],
                                                in_byte_reg[2:0], 4'b0000};
                end
                3'd2, 3'd4:
                begin
                    res_valid  = 1'b1;
                    res_action = ACT_DIGIT;
                    res_target = (digit_inc == 3'd4) ? 8'd1 : 8'd0;
                    res_value  = state_reg.digit_pattern | {4'b0000, in_byte_reg[3:0]};
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
        else
        begin
            state_next.header_count  = '0;
            state_next.in_message    = 1'b0;
            state_next.have_command  = 1'b0;
            state_next.command_code  = '0;
            state_next.cursor_seen   = 1'b0;
            state_next.type_seen     = 1'b0;
            state_next.position_seen = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_port_reg <= '0;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                home_port_reg <= cfg.data;

            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res_valid;
            end
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg   <= din.op;
            in_port_reg <= din.port;
            in_byte_reg <= din.data_byte;
        end
        if (advance && res_valid)
        begin
            out_action_reg <= res_action;
            out_target_reg <= res_target;
            out_value_reg  <= res_value;
        end
    end

endmodule

// ===== hdl/msdcp_chk.sv =====
// Port-level checks of the display command parser, bound to its top level.
module msdcp_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [msdcp_pkg::OP_W-1:0]    in_op,
    input logic [msdcp_pkg::BYTE_W-1:0]  in_data_byte,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [msdcp_pkg::ACTION_W-1:0] out_action,
    input logic [msdcp_pkg::TARGET_W-1:0] out_target,
    input logic [msdcp_pkg::VALUE_W-1:0] out_value
);
    import msdcp_pkg::*;

    // A result word waiting to be taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_action) && $stable(out_target)
                                    && $stable(out_value))
        else $error("result word changed while stalled");

    // The input side stalls only behind a waiting result.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A fresh result comes from a word accepted through the input register and the parse logic.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching input word");

    // Timeouts and status bytes never produce a result.
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_TIMEOUT || in_data_byte[BYTE_W-1])
        |-> ##2 !$rose(out_valid))
        else $error("timeout or status byte produced a result");

endmodule

bind midi_sysex_display_command_parser_top msdcp_chk u_msdcp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (din.valid),
    .in_ready     (din.ready),
    .in_op        (din.op),
    .in_data_byte (din.data_byte),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .out_action   (dout.action),
    .out_target   (dout.target),
    .out_value    (dout.value)
);
